// ----- src/bsas_pkg.sv -----
// ----------------------------------------------------------------------------
// bsas_pkg
// Shared types and constants for the bounded add/sub stack calculator.
// ----------------------------------------------------------------------------
package bsas_pkg;

  localparam int DATA_W  = 32;
  localparam int CAP_W   = 4;
  localparam int COUNT_W = 4;
  localparam int MODE_W  = 2;

  localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POP  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ADD  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SUB  = 2'd3;

  localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

  // What one stack cell does on a request.
  typedef enum logic [2:0] {
    CELL_HOLD,  // keep own word
    CELL_DOWN,  // take word from the cell above (push)
    CELL_UP1,   // take word from one cell below (pop one)
    CELL_UP2,   // take word from two cells below (pop two)
    CELL_LOAD   // take the computed result (top cell only)
  } cell_op_t;

endpackage

// ----- src/bsas_if.sv -----
// ----------------------------------------------------------------------------
// bsas_in_if / bsas_out_if
// Valid/ready channels carrying requests in and results out.
// ----------------------------------------------------------------------------
interface bsas_in_if;
  import bsas_pkg::*;

  logic                       valid;
  logic                       ready;
  logic        [MODE_W-1:0]   mode;
  logic signed [DATA_W-1:0]   push_value;

  modport source (output valid, output mode, output push_value, input ready);
  modport sink   (input valid, input mode, input push_value, output ready);
endinterface

interface bsas_out_if;
  import bsas_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [DATA_W-1:0]   popped_value;
  logic                       popped_valid;
  logic                       full_error;
  logic                       empty_error;
  logic        [COUNT_W-1:0]  count_after;
  logic                       now_full;
  logic                       now_empty;

  modport source (
    output valid, output popped_value, output popped_valid, output full_error,
    output empty_error, output count_after, output now_full, output now_empty,
    input ready
  );
  modport sink (
    input valid, input popped_value, input popped_valid, input full_error,
    input empty_error, input count_after, input now_full, input now_empty,
    output ready
  );
endinterface

// ----- src/bsas_cell.sv -----
// ----------------------------------------------------------------------------
// bsas_cell
// One stack slot: holds a word, takes a neighbor's word on shift or loads a result.
// ----------------------------------------------------------------------------
module bsas_cell
  import bsas_pkg::*;
(
  input  logic                     clk,
  input  cell_op_t                 op,
  input  logic signed [DATA_W-1:0] d_up,
  input  logic signed [DATA_W-1:0] d_dn1,
  input  logic signed [DATA_W-1:0] d_dn2,
  input  logic signed [DATA_W-1:0] d_load,
  output logic signed [DATA_W-1:0] q
);

  always_ff @(posedge clk) begin
    unique case (op)
      CELL_HOLD: q <= q;
      CELL_DOWN: q <= d_up;
      CELL_UP1:  q <= d_dn1;
      CELL_UP2:  q <= d_dn2;
      CELL_LOAD: q <= d_load;
      default:   q <= q;
    endcase
  end

endmodule

// ----- src/bounded_stack_add_sub_top.sv -----
// ----------------------------------------------------------------------------
// bounded_stack_add_sub_top
// Stack of DEPTH words as a row of shifting cells; top cell is slot 0.
// The result is registered in the cycle after a request is accepted.
// Throughput: 1 request per cycle unless the output stalls; top two cells and count are read.
// Reset: count cleared (stack empty), capacity set to 8, no result pending.
// Cell contents are not reset.
// ----------------------------------------------------------------------------
module bounded_stack_add_sub_top
  import bsas_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,
  bsas_in_if.sink          in_ch,
  bsas_out_if.source       out_ch
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [CAP_W-1:0] capacity;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  logic signed [DATA_W-1:0] cell_q [DEPTH];
  logic signed [DATA_W-1:0] top_q;
  logic signed [DATA_W-1:0] second_q;
  cell_op_t                 shift_op;
  logic                     load_top;
  logic signed [DATA_W-1:0] result;

  logic [CAP_W-1:0] eff_cap;
  logic [CMP_W-1:0] cap_x;
  logic             accept;

  logic signed [DATA_W-1:0] first_v;
  logic signed [DATA_W-1:0] second_v;
  logic signed [DATA_W-1:0] out_value;
  logic                     out_pvalid;
  logic                     out_ferr;
  logic                     out_eerr;

  assign eff_cap = (int'(capacity) > DEPTH) ? CAP_W'(DEPTH) : capacity;
  assign cap_x   = CMP_W'(eff_cap);

  assign in_ch.ready = !out_ch.valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign top_q = cell_q[0];
  generate
    if (DEPTH > 1) begin : g_second
      assign second_q = cell_q[1];
    end else begin : g_no_second
      assign second_q = '0;
    end
  endgenerate

  assign first_v  = (count != '0) ? top_q : '0;
  assign second_v = (CMP_W'(count) > CMP_W'(1)) ? second_q : '0;

  // Decide the shift, the new count and the result flags.
  always_comb begin
    shift_op   = CELL_HOLD;
    load_top   = 1'b0;
    result     = '0;
    count_next = count;
    out_value  = '0;
    out_pvalid = 1'b0;
    out_ferr   = 1'b0;
    out_eerr   = 1'b0;
    unique case (in_ch.mode)
      MODE_PUSH: begin
        if (CMP_W'(count) >= cap_x) begin
          out_ferr = 1'b1;
        end else begin
          shift_op   = CELL_DOWN;
          count_next = count + CNT_W'(1);
        end
      end
      MODE_POP: begin
        if (count == '0) begin
          out_eerr = 1'b1;
        end else begin
          shift_op   = CELL_UP1;
          count_next = count - CNT_W'(1);
          out_value  = top_q;
          out_pvalid = 1'b1;
        end
      end
      default: begin
        if (in_ch.mode == MODE_ADD) begin
          result = first_v + second_v;
        end else begin
          result = first_v - second_v;
        end
        out_value = result;
        if (CMP_W'(count) >= CMP_W'(2)) begin
          // both pops hit; push back only if room is left below capacity
          if (CMP_W'(count - CNT_W'(2)) >= cap_x) begin
            shift_op   = CELL_UP2;
            count_next = count - CNT_W'(2);
            out_ferr   = 1'b1;
          end else begin
            shift_op   = CELL_UP1;
            load_top   = 1'b1;
            count_next = count - CNT_W'(1);
            out_pvalid = 1'b1;
          end
        end else begin
          out_eerr = 1'b1;
          if (eff_cap == '0) begin
            count_next = '0;
            out_ferr   = 1'b1;
          end else begin
            load_top   = 1'b1;
            count_next = CNT_W'(1);
            out_pvalid = 1'b1;
          end
        end
      end
    endcase
  end

  generate
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      cell_op_t                 op_i;
      logic signed [DATA_W-1:0] up_i;
      logic signed [DATA_W-1:0] dn1_i;
      logic signed [DATA_W-1:0] dn2_i;

      if (i == 0) begin : g_top
        assign up_i = in_ch.push_value;
        assign op_i = !accept ? CELL_HOLD : (load_top ? CELL_LOAD : shift_op);
      end else begin : g_mid
        assign up_i = cell_q[i-1];
        assign op_i = accept ? shift_op : CELL_HOLD;
      end
      if (i + 1 < DEPTH) begin : g_dn1
        assign dn1_i = cell_q[i+1];
      end else begin : g_dn1_end
        assign dn1_i = '0;
      end
      if (i + 2 < DEPTH) begin : g_dn2
        assign dn2_i = cell_q[i+2];
      end else begin : g_dn2_end
        assign dn2_i = '0;
      end

      bsas_cell u_cell (
        .clk    (clk),
        .op     (op_i),
        .d_up   (up_i),
        .d_dn1  (dn1_i),
        .d_dn2  (dn2_i),
        .d_load (result),
        .q      (cell_q[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity     <= CAP_RESET;
      count        <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (accept) begin
        count        <= count_next;
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_ch.popped_value <= out_value;
      out_ch.popped_valid <= out_pvalid;
      out_ch.full_error   <= out_ferr;
      out_ch.empty_error  <= out_eerr;
      out_ch.count_after  <= COUNT_W'(count_next);
      out_ch.now_full     <= (CMP_W'(count_next) >= cap_x);
      out_ch.now_empty    <= (count_next == '0);
    end
  end

endmodule
